@@ src/url_query_string_decoder_defines.svh @@
// assertion macros used by the query string decoder rtl
`ifndef URL_QUERY_STRING_DECODER_DEFINES_SVH
`define URL_QUERY_STRING_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define UQSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define UQSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/uqsd_pkg.sv @@
// types, character codes and helpers for the query string decoder
`default_nettype none

package uqsd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_KEY_START = 2'd0,
    PH_IN_KEY    = 2'd1,
    PH_IN_VALUE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } escape_t;

  typedef enum logic [2:0] {
    EK_NONE        = 3'd0,
    EK_KEY_VALUE   = 3'd1,
    EK_KEY_ONLY    = 3'd2,
    EK_VALUE_END   = 3'd3,
    EK_VALUE_EMPTY = 3'd4
  } end_kind_t;

  typedef struct packed {
    phase_t     phase;
    escape_t    escape_step;
    logic [3:0] high_nibble;
    logic       value_has_bytes;
    logic       error_seen;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:           PH_KEY_START,
    escape_step:     ESC_NONE,
    high_nibble:     4'd0,
    value_has_bytes: 1'b0,
    error_seen:      1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_value;
    end_kind_t  end_kind;
    logic       parse_error;
    logic       query_done;
  } result_t;

  // msb set when the character is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/uqsd_in_if.sv @@
// input and output channel interfaces of the query string decoder
`default_nettype none

interface uqsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface uqsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       in_value;
  logic [2:0] end_kind;
  logic       parse_error;
  logic       query_done;

  modport source (output valid, output out_byte, output byte_valid, output in_value,
                  output end_kind, output parse_error, output query_done, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input in_value,
                input end_kind, input parse_error, input query_done, output ready);
endinterface

`default_nettype wire

@@ src/url_query_string_decoder.sv @@
// Query string decoder: takes one raw character per transaction and returns exactly one
// result per character, one character per cycle sustained while results are taken. A
// character is captured in an input register and decoded against the parser state by
// combinational logic. The result register is loaded from the input register when the
// result register is free or its result is taken in that cycle. The parser state (phase,
// escape step, high nibble, value flag, sticky error) is updated in that same decode
// cycle, which sets the one-per-cycle rate. The input side keeps accepting while a
// result waits to be taken. It stalls only when both registers are full and the waiting
// result is not taken in that cycle. After the final character of a query all parser
// state, the error flag included, returns to reset.
`default_nettype none

module url_query_string_decoder (
  input  logic           clk,
  input  logic           rst,
  uqsd_in_if.sink        in_ch,
  uqsd_out_if.source     out_ch
);

`include "url_query_string_decoder_defines.svh"

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              o_valid;
  uqsd_pkg::result_t o_res;
  uqsd_pkg::state_t  state;
  uqsd_pkg::state_t  state_next;
  uqsd_pkg::result_t res_next;
  logic              s1_adv;

  assign s1_adv      = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  uqsd_core u_core (
    .st      (state),
    .in_byte (s1_byte),
    .in_last (s1_last),
    .st_next (state_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
      state    <= uqsd_pkg::STATE_RESET;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid <= 1'b1;
        s1_byte  <= in_ch.in_byte;
        s1_last  <= in_ch.in_last;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        o_valid <= 1'b1;
        o_res   <= res_next;
        state   <= state_next;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.out_byte    = o_res.out_byte;
  assign out_ch.byte_valid  = o_res.byte_valid;
  assign out_ch.in_value    = o_res.in_value;
  assign out_ch.end_kind    = o_res.end_kind;
  assign out_ch.parse_error = o_res.parse_error;
  assign out_ch.query_done  = o_res.query_done;

  `UQSD_ASSERT_NXT(a_reset_after_last, s1_adv && s1_last,
                   state == uqsd_pkg::STATE_RESET,
                   "state not cleared after final character")
  `UQSD_ASSERT_IMP(a_no_zero_byte, o_valid && o_res.byte_valid,
                   o_res.out_byte != 8'd0,
                   "decoded zero byte emitted")
  `UQSD_ASSERT_IMP(a_empty_value, o_valid && o_res.end_kind == uqsd_pkg::EK_VALUE_EMPTY,
                   o_res.in_value && !o_res.byte_valid,
                   "empty value marker outside a value")
  `UQSD_ASSERT_IMP(a_ready_when_free, !s1_valid, in_ch.ready,
                   "input stalled with empty input register")

endmodule

`default_nettype wire

@@ src/uqsd_core.sv @@
// per-character decode: next state and result from current state and one character
`default_nettype none

module uqsd_core (
  input  uqsd_pkg::state_t  st,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output uqsd_pkg::state_t  st_next,
  output uqsd_pkg::result_t res
);

  uqsd_pkg::phase_t  ph;
  logic              esc_pend;
  logic [4:0]        hx;
  logic [7:0]        d_ob;
  logic              d_bv;
  logic              d_err;
  uqsd_pkg::escape_t d_esc;
  logic [3:0]        d_hn;
  logic              d_pend;
  logic              err;
  logic              is_sep;
  uqsd_pkg::state_t  nxt;

  assign esc_pend = (st.escape_step == uqsd_pkg::ESC_HIGH) ||
                    (st.escape_step == uqsd_pkg::ESC_LOW);
  assign hx       = uqsd_pkg::hex_val(in_byte);
  assign is_sep   = (in_byte == uqsd_pkg::CH_EQ) || (in_byte == uqsd_pkg::CH_AMP);

  always_comb begin
    ph = st.phase;
    if (st.phase != uqsd_pkg::PH_IN_KEY && st.phase != uqsd_pkg::PH_IN_VALUE) begin
      ph = uqsd_pkg::PH_KEY_START;
    end
  end

  // data character, escape handling
  always_comb begin
    d_ob  = 8'd0;
    d_bv  = 1'b0;
    d_err = 1'b0;
    d_esc = uqsd_pkg::ESC_NONE;
    d_hn  = st.high_nibble;
    case (st.escape_step)
      uqsd_pkg::ESC_HIGH: begin
        if (hx[4]) begin
          d_err = 1'b1;
        end else begin
          d_hn  = hx[3:0];
          d_esc = uqsd_pkg::ESC_LOW;
        end
      end
      uqsd_pkg::ESC_LOW: begin
        if (hx[4] || {st.high_nibble, hx[3:0]} == 8'd0) begin
          d_err = 1'b1;
        end else begin
          d_ob = {st.high_nibble, hx[3:0]};
          d_bv = 1'b1;
        end
      end
      default: begin
        if (in_byte == uqsd_pkg::CH_PCT) begin
          d_esc = uqsd_pkg::ESC_HIGH;
        end else if (in_byte == uqsd_pkg::CH_PLUS) begin
          d_ob = uqsd_pkg::CH_SPACE;
          d_bv = 1'b1;
        end else if (in_byte == 8'd0) begin
          d_err = 1'b1;
        end else begin
          d_ob = in_byte;
          d_bv = 1'b1;
        end
      end
    endcase
    d_pend = (d_esc != uqsd_pkg::ESC_NONE);
  end

  always_comb begin
    nxt            = st;
    nxt.phase      = ph;
    res.out_byte   = 8'd0;
    res.byte_valid = 1'b0;
    res.in_value   = 1'b0;
    res.end_kind   = uqsd_pkg::EK_NONE;
    res.query_done = in_last;
    err            = 1'b0;
    if (ph == uqsd_pkg::PH_KEY_START && is_sep) begin
      // separator before a key is skipped
    end else if (ph != uqsd_pkg::PH_IN_VALUE) begin
      if (is_sep) begin
        err             = esc_pend;
        nxt.escape_step = uqsd_pkg::ESC_NONE;
        if (in_byte == uqsd_pkg::CH_EQ && !in_last) begin
          res.end_kind        = uqsd_pkg::EK_KEY_VALUE;
          nxt.phase           = uqsd_pkg::PH_IN_VALUE;
          nxt.value_has_bytes = 1'b0;
        end else begin
          res.end_kind = uqsd_pkg::EK_KEY_ONLY;
          nxt.phase    = uqsd_pkg::PH_KEY_START;
        end
      end else begin
        nxt.phase       = uqsd_pkg::PH_IN_KEY;
        res.out_byte    = d_ob;
        res.byte_valid  = d_bv;
        nxt.escape_step = d_esc;
        nxt.high_nibble = d_hn;
        err             = d_err || (in_last && d_pend);
        if (in_last) begin
          res.end_kind = uqsd_pkg::EK_KEY_ONLY;
        end
      end
    end else begin
      res.in_value = 1'b1;
      if (in_byte == uqsd_pkg::CH_AMP) begin
        err                 = esc_pend;
        nxt.escape_step     = uqsd_pkg::ESC_NONE;
        res.end_kind        = st.value_has_bytes ? uqsd_pkg::EK_VALUE_END
                                                 : uqsd_pkg::EK_VALUE_EMPTY;
        nxt.phase           = uqsd_pkg::PH_KEY_START;
        nxt.value_has_bytes = 1'b0;
      end else begin
        nxt.value_has_bytes = 1'b1;
        res.out_byte        = d_ob;
        res.byte_valid      = d_bv;
        nxt.escape_step     = d_esc;
        nxt.high_nibble     = d_hn;
        err                 = d_err || (in_last && d_pend);
        if (in_last) begin
          res.end_kind = uqsd_pkg::EK_VALUE_END;
        end
      end
    end
    nxt.error_seen  = st.error_seen || err;
    res.parse_error = nxt.error_seen;
    st_next         = in_last ? uqsd_pkg::STATE_RESET : nxt;
  end

endmodule

`default_nettype wire
